// ===== hdl/bbnp_pkg.sv =====
// Shared constants and codes of the branch-and-bound node pool.
package bbnp_pkg;

  // Default sizes
  localparam int unsigned POOL_DEPTH_DEF     = 64;
  localparam int unsigned HANDLE_BITS_DEF    = 16;
  localparam int unsigned OBJECTIVE_BITS_DEF = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAXIMIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BOUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_KNOWN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT  = 3'd7;

  // Reset values of the registers
  localparam logic [1:0] LEVEL_RST      = 2'd1;
  localparam logic [6:0] NODE_LIMIT_RST = 7'd64;

  // Actions
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_INSPECT = 2'd1;
  localparam logic [1:0] ACT_SELECT  = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // Verdicts
  localparam logic [2:0] VRD_CUTOFF   = 3'd0;
  localparam logic [2:0] VRD_QUEUED   = 3'd1;
  localparam logic [2:0] VRD_NEW_INC  = 3'd2;
  localparam logic [2:0] VRD_OVERFLOW = 3'd3;
  localparam logic [2:0] VRD_SELECTED = 3'd4;
  localparam logic [2:0] VRD_STOP     = 3'd5;
  localparam logic [2:0] VRD_STARTED  = 3'd6;

  // Search levels
  localparam logic [1:0] LVL_FIRST      = 2'd0;
  localparam logic [1:0] LVL_EXHAUSTIVE = 2'd2;

  // Search modes
  localparam logic [1:0] MODE_INIT_DFS  = 2'd0;
  localparam logic [1:0] MODE_EXH_DFS   = 2'd1;
  localparam logic [1:0] MODE_EXH_BEST  = 2'd2;
  localparam logic [1:0] MODE_CONS_BEST = 2'd3;

  // Reciprocal of 5 for the depth/20 term (exact for 14-bit values)
  localparam logic [31:0] RECIP5 = 32'd52429;
  localparam int unsigned RECIP5_SHIFT = 18;

endpackage

// ===== hdl/branch_bound_node_pool.sv =====
// Active-node pool of a branch-and-bound search: pool memory, scan sequencer, mode logic.
//
//  channel | direction | handshake               | payload
//  cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//  in      | in        | in_valid_i / in_stall_o | action, node fields
//  out     | out       | out_valid_o/out_stall_i | verdict and state fields
//
// Start loads its result directly; inspect also runs a compaction scan when a new
// incumbent prunes the pool. Select goes straight to output when it stops, else runs
// the remainder divider (one bit a cycle, skipped when depth is below 2) and one scan
// of the pool, two scans for best first, over the single read port.
// One item at a time: in_stall_o is high from acceptance until the result is
// loaded into the output register. Reset clears control state and counters;
// the pool memory is not cleared, only entries below the fill count are read.
module branch_bound_node_pool #(
  parameter int unsigned POOL_DEPTH     = bbnp_pkg::POOL_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS    = bbnp_pkg::HANDLE_BITS_DEF,
  parameter int unsigned OBJECTIVE_BITS = bbnp_pkg::OBJECTIVE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bbnp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bbnp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          action_i,
  input  logic [HANDLE_BITS-1:0]              node_handle_i,
  input  logic [OBJECTIVE_BITS-1:0]           node_objective_i,
  input  logic                                node_infeasible_i,
  input  logic                                node_integral_i,
  input  logic [OBJECTIVE_BITS-1:0]           improved_objective_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          verdict_o,
  output logic [HANDLE_BITS-1:0]              chosen_handle_o,
  output logic [1:0]                          search_mode_o,
  output logic [OBJECTIVE_BITS-1:0]           incumbent_value_o,
  output logic [OBJECTIVE_BITS-1:0]           bound_value_o,
  output logic [$clog2(POOL_DEPTH+1)-1:0]     active_count_o,
  output logic                                has_incumbent_o
);

  localparam int unsigned OW    = OBJECTIVE_BITS;
  localparam int unsigned HB    = HANDLE_BITS;
  localparam int unsigned IDX_W = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int unsigned SW    = ((OW > 16) ? OW : 16) + 1;
  localparam int unsigned MW    = ((CMP_W > 16) ? CMP_W : 16) + 2;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INSP  = 4'd1;
  localparam logic [3:0] ST_PRUNE = 4'd2;
  localparam logic [3:0] ST_SCHK  = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_MODE  = 4'd5;
  localparam logic [3:0] ST_FIND  = 4'd6;
  localparam logic [3:0] ST_COMP  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  // oriented key: order-preserving unsigned form, flipped for maximize
  function automatic logic [OW-1:0] okey(input logic [OW-1:0] raw, input logic mx);
    logic [OW-1:0] k;
    k = raw ^ {1'b1, {(OW-1){1'b0}}};
    return mx ? ~k : k;
  endfunction

  // k below base + tolerance, carried one bit wider so it cannot wrap
  function automatic logic below(input logic [OW-1:0] k, input logic [OW-1:0] b,
                                 input logic [15:0] tol, input logic strict);
    logic [SW-1:0] lim;
    lim = SW'(b) + SW'(tol);
    return strict ? (SW'(k) < lim) : (SW'(k) <= lim);
  endfunction

  // configuration registers
  logic          max_q;
  logic [1:0]    lvl_q;
  logic [15:0]   tol_q;
  logic [OW-1:0] sbound_q;
  logic          sknown_q;
  logic [15:0]   nvar_q;
  logic [6:0]    nlim_q;
  logic [31:0]   ilim_q;

  // search state
  logic [3:0]       state_q;
  logic [CNT_W-1:0] size_q;
  logic [OW-1:0]    inc_q;
  logic             found_q;
  logic [OW-1:0]    bb_q;
  logic [31:0]      ic_q;

  // captured item
  logic [HB-1:0] hdl_q;
  logic [OW-1:0] obj_q;
  logic          inf_q;
  logic          int_q;
  logic [OW-1:0] imp_q;

  // sequencer working registers
  logic [2:0]       verdict_q;
  logic [1:0]       mode_q;
  logic [HB-1:0]    chosen_q;
  logic [CNT_W-1:0] sp_q;
  logic [CNT_W-1:0] wp_q;
  logic             dv_q;
  logic [IDX_W-1:0] da_q;
  logic             have_q;
  logic [OW-1:0]    bestk_q;
  logic [IDX_W-1:0] sel_q;
  logic [31:0]      num_q;
  logic [15:0]      rem_q;
  logic [4:0]       dcnt_q;

  // output register
  logic             out_vld_q;
  logic [2:0]       o_verdict_q;
  logic [HB-1:0]    o_handle_q;
  logic [1:0]       o_mode_q;
  logic [OW-1:0]    o_inc_q;
  logic [OW-1:0]    o_bb_q;
  logic [CNT_W-1:0] o_size_q;
  logic             o_found_q;

  // pool memory
  logic [HB-1:0]    pool_h [POOL_DEPTH];
  logic [OW-1:0]    pool_o [POOL_DEPTH];
  logic [HB-1:0]    rd_h_q;
  logic [OW-1:0]    rd_o_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [HB-1:0]    mem_wh;
  logic [OW-1:0]    mem_wo;

  // derived values
  logic [CMP_W-1:0] cap;
  logic             full;
  logic [OW-1:0]    inc_key;
  logic [OW-1:0]    obj_key;
  logic [OW-1:0]    rkey;
  logic             obj_pass;
  logic             bb_pass;
  logic             stop;
  logic             issue;
  logic             scan_done;
  logic             keep;
  logic [15:0]      div_t;
  logic [15:0]      div_r;
  logic [18:0]      five_d;
  logic [15:0]      d20;
  logic [MW-1:0]    room;
  logic [MW-1:0]    three_sz;
  logic [MW-1:0]    two_cap;
  logic [1:0]       mode_n;

  // capacity and acceptance tests
  always_comb begin
    cap = (CMP_W'(nlim_q) < CMP_W'(POOL_DEPTH)) ? CMP_W'(nlim_q) : CMP_W'(POOL_DEPTH);
    full = CMP_W'(size_q) >= cap;
    inc_key = okey(inc_q, max_q);
    obj_key = okey(obj_q, max_q);
    rkey = okey(rd_o_q, max_q);
    obj_pass = below(obj_key, inc_key, tol_q, 1'b1) ||
               (below(obj_key, inc_key, tol_q, 1'b0) && !found_q);
    bb_pass = below(okey(bb_q, max_q), inc_key, tol_q, 1'b1) ||
              (below(okey(bb_q, max_q), inc_key, tol_q, 1'b0) && !found_q);
    stop = (size_q == '0) || full || ((lvl_q == bbnp_pkg::LVL_FIRST) && found_q) ||
           !bb_pass || ((ilim_q != '0) && (ic_q >= ilim_q));
  end

  // scan pointer: one read a cycle, data valid in the next cycle
  always_comb begin
    issue = sp_q < size_q;
    scan_done = !issue && !dv_q;
    if (state_q == ST_PRUNE) begin
      keep = below(rkey, inc_key, tol_q, 1'b1);
    end else begin
      keep = da_q != sel_q;
    end
  end

  // restoring remainder step
  always_comb begin
    div_t = {rem_q[14:0], num_q[31]};
    div_r = (div_t >= {1'b0, nvar_q[15:1]}) ? (div_t - {1'b0, nvar_q[15:1]}) : div_t;
  end

  // search mode from the counters
  always_comb begin
    five_d = 19'(nvar_q) * 19'd5;
    d20 = 16'((32'(nvar_q[15:2]) * bbnp_pkg::RECIP5) >> bbnp_pkg::RECIP5_SHIFT);
    room = MW'(size_q) + MW'(nvar_q) + MW'(2);
    three_sz = MW'(size_q) * MW'(3);
    two_cap = MW'(cap) * MW'(2);
    if ((ic_q < 32'(five_d)) && (lvl_q != bbnp_pkg::LVL_EXHAUSTIVE)) begin
      mode_n = bbnp_pkg::MODE_INIT_DFS;
    end else if (room > MW'(cap)) begin
      mode_n = bbnp_pkg::MODE_EXH_DFS;
    end else if ((lvl_q != bbnp_pkg::LVL_EXHAUSTIVE) && (nvar_q >= 16'd2) &&
                 (rem_q > d20)) begin
      mode_n = bbnp_pkg::MODE_EXH_DFS;
    end else if ((lvl_q == bbnp_pkg::LVL_EXHAUSTIVE) || (three_sz > two_cap)) begin
      mode_n = bbnp_pkg::MODE_EXH_BEST;
    end else begin
      mode_n = bbnp_pkg::MODE_CONS_BEST;
    end
  end

  // memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = size_q[IDX_W-1:0];
    mem_wh = hdl_q;
    mem_wo = obj_q;
    case (state_q)
      ST_INSP: begin
        mem_we = !(inf_q || !obj_pass) && !int_q && !full;
      end
      ST_PRUNE, ST_COMP: begin
        mem_we = dv_q && keep;
        mem_wa = wp_q[IDX_W-1:0];
        mem_wh = rd_h_q;
        mem_wo = rd_o_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // pool memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pool_h[mem_wa] <= mem_wh;
      pool_o[mem_wa] <= mem_wo;
    end
    rd_h_q <= pool_h[sp_q[IDX_W-1:0]];
    rd_o_q <= pool_o[sp_q[IDX_W-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= 1'b0;
      lvl_q    <= bbnp_pkg::LEVEL_RST;
      tol_q    <= '0;
      sbound_q <= '0;
      sknown_q <= 1'b0;
      nvar_q   <= '0;
      nlim_q   <= bbnp_pkg::NODE_LIMIT_RST;
      ilim_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbnp_pkg::CFG_MAXIMIZE:    max_q    <= cfg_data_i[0];
        bbnp_pkg::CFG_LEVEL:       lvl_q    <= cfg_data_i[1:0];
        bbnp_pkg::CFG_TOLERANCE:   tol_q    <= cfg_data_i[15:0];
        bbnp_pkg::CFG_START_BOUND: sbound_q <= OW'(signed'(cfg_data_i));
        bbnp_pkg::CFG_START_KNOWN: sknown_q <= cfg_data_i[0];
        bbnp_pkg::CFG_VAR_COUNT:   nvar_q   <= cfg_data_i[15:0];
        bbnp_pkg::CFG_NODE_LIMIT:  nlim_q   <= cfg_data_i[6:0];
        bbnp_pkg::CFG_ITER_LIMIT:  ilim_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      size_q    <= '0;
      inc_q     <= '0;
      found_q   <= 1'b0;
      bb_q      <= '0;
      ic_q      <= '0;
      hdl_q     <= '0;
      obj_q     <= '0;
      inf_q     <= 1'b0;
      int_q     <= 1'b0;
      imp_q     <= '0;
      verdict_q <= '0;
      mode_q    <= '0;
      chosen_q  <= '0;
      sp_q      <= '0;
      wp_q      <= '0;
      dv_q      <= 1'b0;
      da_q      <= '0;
      have_q    <= 1'b0;
      bestk_q   <= '0;
      sel_q     <= '0;
      num_q     <= '0;
      rem_q     <= '0;
      dcnt_q    <= '0;
      out_vld_q   <= 1'b0;
      o_verdict_q <= '0;
      o_handle_q  <= '0;
      o_mode_q    <= '0;
      o_inc_q     <= '0;
      o_bb_q      <= '0;
      o_size_q    <= '0;
      o_found_q   <= 1'b0;
    end else begin
      // output beat taken and nothing new to load
      if (out_vld_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            hdl_q <= node_handle_i;
            obj_q <= node_objective_i;
            inf_q <= node_infeasible_i;
            int_q <= node_integral_i;
            imp_q <= improved_objective_i;
            case (action_i)
              bbnp_pkg::ACT_START: begin
                size_q    <= '0;
                ic_q      <= '0;
                inc_q     <= sbound_q;
                found_q   <= sknown_q;
                bb_q      <= sbound_q;
                verdict_q <= bbnp_pkg::VRD_STARTED;
                state_q   <= ST_OUT;
              end
              bbnp_pkg::ACT_INSPECT: state_q <= ST_INSP;
              bbnp_pkg::ACT_SELECT:  state_q <= ST_SCHK;
              default:               state_q <= ST_IDLE;
            endcase
          end
        end
        ST_INSP: begin
          if (ic_q != '1) begin
            ic_q <= ic_q + 32'd1;
          end
          if (inf_q || !obj_pass) begin
            verdict_q <= bbnp_pkg::VRD_CUTOFF;
            state_q   <= ST_OUT;
          end else if (int_q) begin
            found_q   <= 1'b1;
            inc_q     <= imp_q;
            verdict_q <= bbnp_pkg::VRD_NEW_INC;
            sp_q      <= '0;
            wp_q      <= '0;
            dv_q      <= 1'b0;
            state_q   <= ST_PRUNE;
          end else if (full) begin
            verdict_q <= bbnp_pkg::VRD_OVERFLOW;
            state_q   <= ST_OUT;
          end else begin
            if ((size_q == '0) || (obj_key < okey(bb_q, max_q))) begin
              bb_q <= obj_q;
            end
            size_q    <= size_q + CNT_W'(1);
            verdict_q <= bbnp_pkg::VRD_QUEUED;
            state_q   <= ST_OUT;
          end
        end
        // compact the pool, keeping entries that can still beat the incumbent
        ST_PRUNE: begin
          if (issue) begin
            sp_q <= sp_q + CNT_W'(1);
          end
          dv_q <= issue;
          da_q <= sp_q[IDX_W-1:0];
          if (dv_q && keep) begin
            wp_q <= wp_q + CNT_W'(1);
          end
          if (scan_done) begin
            size_q  <= wp_q;
            state_q <= ST_OUT;
          end
        end
        ST_SCHK: begin
          num_q  <= ic_q;
          rem_q  <= '0;
          dcnt_q <= '0;
          if (stop) begin
            verdict_q <= bbnp_pkg::VRD_STOP;
            state_q   <= ST_OUT;
          end else if (nvar_q >= 16'd2) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_MODE;
          end
        end
        // inspected count mod (depth/2), one bit a cycle
        ST_DIV: begin
          rem_q  <= div_r;
          num_q  <= {num_q[30:0], 1'b0};
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd31) begin
            state_q <= ST_MODE;
          end
        end
        ST_MODE: begin
          mode_q <= mode_n;
          sp_q   <= '0;
          wp_q   <= '0;
          dv_q   <= 1'b0;
          have_q <= 1'b0;
          if ((mode_n == bbnp_pkg::MODE_EXH_BEST) || (mode_n == bbnp_pkg::MODE_CONS_BEST)) begin
            state_q <= ST_FIND;
          end else begin
            sel_q   <= IDX_W'(size_q - CNT_W'(1));
            bb_q    <= inc_q;
            state_q <= ST_COMP;
          end
        end
        // best entry, newest wins a tie
        ST_FIND: begin
          if (issue) begin
            sp_q <= sp_q + CNT_W'(1);
          end
          dv_q <= issue;
          da_q <= sp_q[IDX_W-1:0];
          if (dv_q && (!have_q || (rkey <= bestk_q))) begin
            have_q  <= 1'b1;
            bestk_q <= rkey;
            sel_q   <= da_q;
          end
          if (scan_done) begin
            sp_q    <= '0;
            wp_q    <= '0;
            bb_q    <= inc_q;
            state_q <= ST_COMP;
          end
        end
        // remove the chosen entry and rebuild the best bound
        ST_COMP: begin
          if (issue) begin
            sp_q <= sp_q + CNT_W'(1);
          end
          dv_q <= issue;
          da_q <= sp_q[IDX_W-1:0];
          if (dv_q) begin
            if (!keep) begin
              chosen_q <= rd_h_q;
            end else begin
              wp_q <= wp_q + CNT_W'(1);
              if (rkey < okey(bb_q, max_q)) begin
                bb_q <= rd_o_q;
              end
            end
          end
          if (scan_done) begin
            size_q    <= wp_q;
            verdict_q <= bbnp_pkg::VRD_SELECTED;
            state_q   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_vld_q || !out_stall_i) begin
            out_vld_q   <= 1'b1;
            o_verdict_q <= verdict_q;
            o_handle_q  <= (verdict_q == bbnp_pkg::VRD_SELECTED) ? chosen_q : '0;
            o_mode_q    <= (verdict_q == bbnp_pkg::VRD_SELECTED) ? mode_q : '0;
            o_inc_q     <= inc_q;
            o_bb_q      <= bb_q;
            o_size_q    <= size_q;
            o_found_q   <= found_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o        = state_q != ST_IDLE;
  assign out_valid_o       = out_vld_q;
  assign verdict_o         = o_verdict_q;
  assign chosen_handle_o   = o_handle_q;
  assign search_mode_o     = o_mode_q;
  assign incumbent_value_o = o_inc_q;
  assign bound_value_o     = o_bb_q;
  assign active_count_o    = o_size_q;
  assign has_incumbent_o   = o_found_q;

endmodule
